/* sv/ffbp_pkg.sv */
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants for the first-fit bit packer: transaction
// payloads, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffbp_pkg;

    // largest usable word width; wider register values saturate here
    localparam logic [6:0] MAX_WIDTH = 7'd64;

    // result status codes
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_TOO_WIDE = 2'd1;
    localparam logic [1:0] ST_NO_ROOM = 2'd2;

    // input transaction
    typedef struct packed {
        logic [7:0] field_bits;
        logic       last_in_set;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [9:0]  word_index;
        logic [5:0]  bit_offset;
        logic [1:0]  status;
        logic [16:0] total_bits;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // accept item and start a scan at word 0
        logic reject;   // accept item that is wider than the word
        logic scan;     // issue the next fill read
        logic place;    // commit the field into the compared word
        logic fail;     // scan ran off the end with no room
        logic finish;   // present the result and apply end of set
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic too_wide; // incoming field exceeds the effective width
        logic fit;      // compared word has room
        logic scan_end; // compared word is the last one
    } t_stat;

endpackage

`default_nettype wire

/* sv/ffbp_ctrl.sv */
// ----------------------------------------------------------------------------
// ffbp_ctrl
// Sequencing state machine for the bit packer: accepts an item, runs the
// word scan and hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ffbp_pkg::t_stat i_stat,
    output ffbp_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_stat.too_wide) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_FINISH;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.fit) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FINISH;
                end else if (i_stat.scan_end) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* sv/ffbp_datapath.sv */
// ----------------------------------------------------------------------------
// ffbp_datapath
// Fill store, scan address pipeline, fit compare, set bookkeeping and the
// registered result for the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbp_datapath #(
    parameter int WORD_COUNT = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [6:0]      i_cfg_wdata,
    input  wire ffbp_pkg::t_in   i_in,
    input  wire ffbp_pkg::t_cmd  i_cmd,
    output ffbp_pkg::t_stat      o_stat,
    output ffbp_pkg::t_out       o_result,
    output logic                 o_done
);

    localparam int ADDR_W = $clog2(WORD_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

    // fill store, contents at and above the used count are treated as zero
    logic [6:0] mem [WORD_COUNT];

    logic [6:0]        r_cfg_width;
    logic [7:0]        r_size;
    logic              r_last;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [ADDR_W-1:0] r_cmp_addr;
    logic              r_cmp_valid;
    logic              r_beyond;
    logic [6:0]        r_mem_q;
    logic [ADDR_W:0]   r_used;
    logic [6:0]        r_top_fill;
    logic [ADDR_W-1:0] r_res_index;
    logic [5:0]        r_res_offset;
    logic [1:0]        r_res_status;
    ffbp_pkg::t_out    r_out;
    logic              r_done;

    logic [6:0]          width_eff;
    logic [6:0]          fill_eff;
    logic [8:0]          fill_sum;
    logic                fits;
    logic [ADDR_W:0]     cmp_ext;
    logic [ADDR_W:0]     used_m1;
    logic [ADDR_W-1:0]   hi_word;
    logic [ADDR_W+6:0]   product;
    logic [ADDR_W+6:0]   total_sum;
    logic [ADDR_W+23:0]  total_ext;
    logic [ADDR_W+9:0]   index_ext;

    // effective width saturates at the maximum
    assign width_eff = (r_cfg_width > ffbp_pkg::MAX_WIDTH) ? ffbp_pkg::MAX_WIDTH : r_cfg_width;

    // fit compare on the word read in the previous cycle
    assign fill_eff = r_beyond ? 7'd0 : r_mem_q;
    assign fill_sum = {2'b00, fill_eff} + {1'b0, r_size};
    assign fits     = (fill_sum <= {2'b00, width_eff});
    assign cmp_ext  = {1'b0, r_cmp_addr};

    assign o_stat.too_wide = ({1'b0, i_in.field_bits} > {2'b00, width_eff});
    assign o_stat.fit      = r_cmp_valid && fits;
    assign o_stat.scan_end = r_cmp_valid && (r_cmp_addr == LAST_ADDR);

    // total bits from the highest used word and its fill
    assign used_m1   = r_used - 1'b1;
    assign hi_word   = (r_used == '0) ? '0 : used_m1[ADDR_W-1:0];
    assign product   = (ADDR_W+7)'(hi_word) * (ADDR_W+7)'(width_eff);
    assign total_sum = product + (ADDR_W+7)'(r_top_fill);
    assign total_ext = (ADDR_W+24)'(total_sum);
    assign index_ext = (ADDR_W+10)'(r_res_index);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= ffbp_pkg::MAX_WIDTH;
        end else if (i_cfg_we) begin
            r_cfg_width <= i_cfg_wdata;
        end
    end

    // fill store read and write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (r_rd_addr <= LAST_ADDR)) begin
            r_mem_q <= mem[r_rd_addr];
        end
        if (i_cmd.place) begin
            mem[r_cmp_addr] <= fill_sum[6:0];
        end
    end

    // item capture and scan address pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.reject) begin
            r_size <= i_in.field_bits;
            r_last <= i_in.last_in_set;
        end
        if (i_cmd.load) begin
            r_rd_addr <= '0;
        end else if (i_cmd.scan) begin
            r_rd_addr  <= r_rd_addr + 1'b1;
            r_cmp_addr <= r_rd_addr;
            r_beyond   <= ({1'b0, r_rd_addr} >= r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.load || i_cmd.place || i_cmd.fail) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_valid <= 1'b1;
        end
    end

    // per item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.reject) begin
            r_res_index  <= '0;
            r_res_offset <= '0;
            r_res_status <= ffbp_pkg::ST_TOO_WIDE;
        end else if (i_cmd.fail) begin
            r_res_index  <= '0;
            r_res_offset <= '0;
            r_res_status <= ffbp_pkg::ST_NO_ROOM;
        end else if (i_cmd.place) begin
            r_res_index  <= r_cmp_addr;
            r_res_offset <= fill_eff[5:0];
            r_res_status <= ffbp_pkg::ST_PLACED;
        end
    end

    // set bookkeeping: used word count and fill of the highest word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_top_fill <= '0;
        end else if (i_cmd.finish && r_last) begin
            r_used     <= '0;
            r_top_fill <= '0;
        end else if (i_cmd.place) begin
            if (cmp_ext == r_used) begin
                r_used <= r_used + 1'b1;
            end
            if ((cmp_ext + 1'b1) >= r_used) begin
                r_top_fill <= fill_sum[6:0];
            end
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.word_index <= index_ext[9:0];
            r_out.bit_offset <= r_res_offset;
            r_out.status     <= r_res_status;
            r_out.total_bits <= total_ext[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_result = r_out;
    assign o_done   = r_done;

endmodule

`default_nettype wire

/* sv/first_fit_bit_packer.sv */
// ----------------------------------------------------------------------------
// first_fit_bit_packer
// Places bit fields into fixed-width words by first fit and reports the word,
// the starting bit, a status code and the total bits used by the set.
//
//   channel   | signals                    | handshake
//   ----------+----------------------------+----------------------------------
//   input     | start, busy, i_in          | taken when start && !busy
//   result    | o_done, o_result           | one cycle strobe, no back-pressure
//   config    | i_cfg_we, i_cfg_wdata      | written when i_cfg_we is high
//
// An item keeps busy high from acceptance until its result, so the next
// item waits; the scan reads one word fill per cycle from the fill store,
// which has a read port and a separate write port. A field wider than the
// word is rejected without a scan, and an item that finds no room scans
// every word. The result strobe rises in the cycle busy falls. Reset is
// synchronous and needs no clearing pass: a used-word count masks stale
// fills, and end of set resets it. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_bit_packer #(
    parameter int WORD_COUNT = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [6:0]     i_cfg_wdata,
    input  wire logic           start,
    output logic                busy,
    input  wire ffbp_pkg::t_in  i_in,
    output logic                o_done,
    output ffbp_pkg::t_out      o_result
);

    ffbp_pkg::t_cmd  cmd;
    ffbp_pkg::t_stat stat;

    // sequencing
    ffbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // fill store and arithmetic
    ffbp_datapath #(
        .WORD_COUNT (WORD_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_done      (o_done)
    );

endmodule

`default_nettype wire
